/* rtl/core/lcfpf_pkg.sv */
// Shared widths, register codes, reset values, types and helpers of the field-of-view point filter.
package lcfpf_pkg;

    // Field widths.
    localparam int COORD_WIDTH = 20;
    localparam int PIXEL_WIDTH = 12;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 14;

    // Datapath widths: one rotation product, a camera-frame coordinate and a projection term.
    localparam int PROD_W = COEF_BITS + COORD_WIDTH;
    localparam int CAM_W  = PROD_W + 1;
    localparam int SUM_W  = CAM_W + PIXEL_WIDTH + 3;

    // Configuration port.
    localparam int ROT_W      = 3 * COEF_BITS;
    localparam int TRANS_W    = 3 * COORD_WIDTH;
    localparam int DEPTH_W    = COORD_WIDTH - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (TRANS_W > ROT_W) ? TRANS_W : ROT_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_0   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_1   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_2   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL       = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE        = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH   = CFG_IDX_W'(7);

    // Reset values: identity rotation, no offset, a 640 by 480 image centred on (320, 240).
    localparam logic [63:0] COEF_ONE = 64'd1 << FRAC_BITS;
    localparam logic [ROT_W-1:0] ROT_ROW_0_RST = ROT_W'(COEF_ONE << (2 * COEF_BITS));
    localparam logic [ROT_W-1:0] ROT_ROW_1_RST = ROT_W'(COEF_ONE << COEF_BITS);
    localparam logic [ROT_W-1:0] ROT_ROW_2_RST = ROT_W'(COEF_ONE);
    localparam logic [TRANS_W-1:0] TRANS_RST = '0;
    localparam logic [PIXEL_WIDTH-1:0] FOCAL_RST = PIXEL_WIDTH'(320);
    localparam logic [2*PIXEL_WIDTH-1:0] CENTER_RST =
        {PIXEL_WIDTH'(320), PIXEL_WIDTH'(240)};
    localparam logic [2*PIXEL_WIDTH-1:0] SIZE_RST =
        {PIXEL_WIDTH'(640), PIXEL_WIDTH'(480)};
    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = DEPTH_W'(102);

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0][ROT_W-1:0]      rot;
        logic [TRANS_W-1:0]         trans;
        logic [PIXEL_WIDTH-1:0]     focal;
        logic [2*PIXEL_WIDTH-1:0]   center;
        logic [2*PIXEL_WIDTH-1:0]   size;
        logic [DEPTH_W-1:0]         min_depth;
    } cfg_t;

    // One lidar point with its scan marker.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          frame_end;
    } point_t;

    // A point together with its camera-frame coordinates in units of 2^-24 m.
    typedef struct packed {
        point_t                  pt;
        logic signed [CAM_W-1:0] xc;
        logic signed [CAM_W-1:0] yc;
        logic signed [CAM_W-1:0] zc;
    } cam_t;

    // Coefficient of a rotation row; column 0 sits in the top bits.
    function automatic logic signed [COEF_BITS-1:0] coef(
        input logic [ROT_W-1:0] row,
        input int unsigned      col
    );
        coef = $signed(row[COEF_BITS*(2-col) +: COEF_BITS]);
    endfunction

    // Translation offset of one axis; x sits in the top bits.
    function automatic logic signed [COORD_WIDTH-1:0] offset(
        input logic [TRANS_W-1:0] trans,
        input int unsigned        axis
    );
        offset = $signed(trans[COORD_WIDTH*(2-axis) +: COORD_WIDTH]);
    endfunction

endpackage

/* rtl/core/lidar_camera_fov_point_filter.sv */
// Top level of the lidar point filter against the camera field of view.
// Each accepted input beat gives one result beat on the output, in input order.
// Throughput: one point per cycle unless the output stalls; stages share no multipliers.
// The four stages are rotation products, row sums, projection products and bound compares.
// Reset clears every stage's valid bit and loads the configuration defaults
// (identity rotation, no offset, focal 320, 640 by 480 image centred, depth 102).
module lidar_camera_fov_point_filter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [lcfpf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lcfpf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [lcfpf_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [lcfpf_pkg::COORD_WIDTH-1:0] point_y,
    input  logic signed [lcfpf_pkg::COORD_WIDTH-1:0] point_z,
    input  logic                                     frame_end,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [lcfpf_pkg::COORD_WIDTH-1:0] kept_x,
    output logic signed [lcfpf_pkg::COORD_WIDTH-1:0] kept_y,
    output logic signed [lcfpf_pkg::COORD_WIDTH-1:0] kept_z,
    output logic                                     inside_res,
    output logic                                     scan_end
);

    lcfpf_pkg::cfg_t   cfg;
    lcfpf_pkg::point_t in_pt;
    lcfpf_pkg::cam_t   mid_cam;
    lcfpf_pkg::point_t out_pt;
    logic              mid_valid;
    logic              mid_stall;

    // Input beat gathered into one point.
    assign in_pt.x         = point_x;
    assign in_pt.y         = point_y;
    assign in_pt.z         = point_z;
    assign in_pt.frame_end = frame_end;

    lcfpf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcfpf_transform u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pt     (in_pt),
        .out_valid (mid_valid),
        .out_stall (mid_stall),
        .out_cam   (mid_cam)
    );

    lcfpf_project u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (mid_valid),
        .in_stall   (mid_stall),
        .in_cam     (mid_cam),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_pt     (out_pt),
        .out_inside (inside_res)
    );

    // Result beat taken apart into its fields.
    assign kept_x   = out_pt.x;
    assign kept_y   = out_pt.y;
    assign kept_z   = out_pt.z;
    assign scan_end = out_pt.frame_end;

`ifndef ASSERT_OFF
    // The pipeline only pushes back on its input when the output is held up.
    a_in_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall)
        else $error("input stalled while the output is not stalled");

    // The link between the transform and the projection stalls only under output back-pressure.
    a_mid_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        mid_stall |-> (out_stall && out_valid))
        else $error("internal link stalled without a held result beat");

    // A stalled input implies every stage downstream is full.
    a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (mid_valid && mid_stall))
        else $error("input stalled while the transform output is free");
`endif

endmodule

/* rtl/core/lcfpf_cfg_regs.sv */
// Configuration register file of the field-of-view point filter.
module lcfpf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lcfpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcfpf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lcfpf_pkg::cfg_t                    cfg
);

    lcfpf_pkg::cfg_t cfg_reg;

    // Each write replaces one register with the low bits of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot[0]    <= lcfpf_pkg::ROT_ROW_0_RST;
            cfg_reg.rot[1]    <= lcfpf_pkg::ROT_ROW_1_RST;
            cfg_reg.rot[2]    <= lcfpf_pkg::ROT_ROW_2_RST;
            cfg_reg.trans     <= lcfpf_pkg::TRANS_RST;
            cfg_reg.focal     <= lcfpf_pkg::FOCAL_RST;
            cfg_reg.center    <= lcfpf_pkg::CENTER_RST;
            cfg_reg.size      <= lcfpf_pkg::SIZE_RST;
            cfg_reg.min_depth <= lcfpf_pkg::MIN_DEPTH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lcfpf_pkg::REG_ROT_ROW_0:
                    cfg_reg.rot[0] <= cfg_data[lcfpf_pkg::ROT_W-1:0];
                lcfpf_pkg::REG_ROT_ROW_1:
                    cfg_reg.rot[1] <= cfg_data[lcfpf_pkg::ROT_W-1:0];
                lcfpf_pkg::REG_ROT_ROW_2:
                    cfg_reg.rot[2] <= cfg_data[lcfpf_pkg::ROT_W-1:0];
                lcfpf_pkg::REG_TRANSLATION:
                    cfg_reg.trans <= cfg_data[lcfpf_pkg::TRANS_W-1:0];
                lcfpf_pkg::REG_FOCAL:
                    cfg_reg.focal <= cfg_data[lcfpf_pkg::PIXEL_WIDTH-1:0];
                lcfpf_pkg::REG_CENTER:
                    cfg_reg.center <= cfg_data[2*lcfpf_pkg::PIXEL_WIDTH-1:0];
                lcfpf_pkg::REG_SIZE:
                    cfg_reg.size <= cfg_data[2*lcfpf_pkg::PIXEL_WIDTH-1:0];
                lcfpf_pkg::REG_MIN_DEPTH:
                    cfg_reg.min_depth <= cfg_data[lcfpf_pkg::DEPTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/lcfpf_transform.sv */
// Rigid transform stages: nine rotation products, then the row sums with the offset.
module lcfpf_transform (
    input  logic              clk,
    input  logic              rst_n,
    input  lcfpf_pkg::cfg_t   cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  lcfpf_pkg::point_t in_pt,
    output logic              out_valid,
    input  logic              out_stall,
    output lcfpf_pkg::cam_t   out_cam
);

    logic v1_reg;
    logic v2_reg;
    logic en1;
    logic en2;

    lcfpf_pkg::point_t                         pt1_reg;
    logic signed [lcfpf_pkg::PROD_W-1:0]       prod_reg  [3][3];
    logic signed [lcfpf_pkg::PROD_W-1:0]       prod_next [3][3];
    logic signed [lcfpf_pkg::COORD_WIDTH-1:0]  p_arr     [3];
    logic signed [lcfpf_pkg::CAM_W-1:0]        pc        [3];
    lcfpf_pkg::cam_t                           cam_reg;
    lcfpf_pkg::cam_t                           cam_next;

    // A stage moves on when it is empty or the stage after it moves on.
    assign en2      = !v2_reg || !out_stall;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Stage one: every coefficient times its coordinate, kept at full width.
    always_comb
    begin
        p_arr[0] = in_pt.x;
        p_arr[1] = in_pt.y;
        p_arr[2] = in_pt.z;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = lcfpf_pkg::coef(cfg.rot[i], j) * p_arr[j];
            end
        end
    end

    // Stage two: row sums plus the offset scaled to the product's fraction.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pc[i] = lcfpf_pkg::CAM_W'(prod_reg[i][0])
                  + lcfpf_pkg::CAM_W'(prod_reg[i][1])
                  + lcfpf_pkg::CAM_W'(prod_reg[i][2])
                  + (lcfpf_pkg::CAM_W'(lcfpf_pkg::offset(cfg.trans, i))
                     <<< lcfpf_pkg::FRAC_BITS);
        end
        // Camera axes: right is minus lidar y, down is minus lidar z, depth is lidar x.
        cam_next.pt = pt1_reg;
        cam_next.xc = -pc[1];
        cam_next.yc = -pc[2];
        cam_next.zc = pc[0];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pt1_reg  <= in_pt;
            prod_reg <= prod_next;
        end
        if (en2)
            cam_reg <= cam_next;
    end

    assign out_valid = v2_reg;
    assign out_cam   = cam_reg;

endmodule

/* rtl/core/lcfpf_project.sv */
// Projection stages: depth test and the cross-multiplied image bound tests.
module lcfpf_project (
    input  logic              clk,
    input  logic              rst_n,
    input  lcfpf_pkg::cfg_t   cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  lcfpf_pkg::cam_t   in_cam,
    output logic              out_valid,
    input  logic              out_stall,
    output lcfpf_pkg::point_t out_pt,
    output logic              out_inside
);

    localparam int P = lcfpf_pkg::PIXEL_WIDTH;

    // Products and flags carried from the multiply stage to the compare stage.
    typedef struct packed {
        lcfpf_pkg::point_t                   pt;
        logic signed [lcfpf_pkg::SUM_W-1:0]  fx;
        logic signed [lcfpf_pkg::SUM_W-1:0]  fy;
        logic signed [lcfpf_pkg::SUM_W-1:0]  cu1z;
        logic signed [lcfpf_pkg::SUM_W-1:0]  cv1z;
        logic signed [lcfpf_pkg::SUM_W-1:0]  wz;
        logic signed [lcfpf_pkg::SUM_W-1:0]  hz;
        logic                                depth_ok;
        logic                                w_nz;
        logic                                h_nz;
    } prj_t;

    logic v3_reg;
    logic v4_reg;
    logic en3;
    logic en4;

    prj_t                                prj_reg;
    prj_t                                prj_next;
    lcfpf_pkg::point_t                   pt4_reg;
    logic                                inside_reg;
    logic                                inside_next;

    logic [P-1:0]                        cu;
    logic [P-1:0]                        cv;
    logic [P-1:0]                        img_w;
    logic [P-1:0]                        img_h;
    logic [P:0]                          cu1;
    logic [P:0]                          cv1;
    logic signed [P:0]                   w_m_cu;
    logic signed [P:0]                   h_m_cv;
    logic signed [P:0]                   f_s;
    logic signed [lcfpf_pkg::CAM_W-1:0]  depth_lim;
    logic signed [lcfpf_pkg::SUM_W-1:0]  sum_u;
    logic signed [lcfpf_pkg::SUM_W-1:0]  sum_v;

    // Same advance rule as the transform stages.
    assign en4      = !v4_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign in_stall = !en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_reg <= in_valid;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // Register fields decoded into signed operands.
    assign cu     = cfg.center[2*P-1:P];
    assign cv     = cfg.center[P-1:0];
    assign img_w  = cfg.size[2*P-1:P];
    assign img_h  = cfg.size[P-1:0];
    assign cu1    = {1'b0, cu} + (P+1)'(1);
    assign cv1    = {1'b0, cv} + (P+1)'(1);
    assign w_m_cu = $signed({1'b0, img_w}) - $signed({1'b0, cu});
    assign h_m_cv = $signed({1'b0, img_h}) - $signed({1'b0, cv});
    assign f_s    = $signed({1'b0, cfg.focal});
    assign depth_lim =
        $signed(lcfpf_pkg::CAM_W'({cfg.min_depth, lcfpf_pkg::FRAC_BITS'(0)}));

    // Stage three: the six products of the two bound tests and the depth test.
    always_comb
    begin
        prj_next.pt       = in_cam.pt;
        prj_next.fx       = f_s * in_cam.xc;
        prj_next.fy       = f_s * in_cam.yc;
        prj_next.cu1z     = $signed({1'b0, cu1}) * in_cam.zc;
        prj_next.cv1z     = $signed({1'b0, cv1}) * in_cam.zc;
        prj_next.wz       = w_m_cu * in_cam.zc;
        prj_next.hz       = h_m_cv * in_cam.zc;
        prj_next.depth_ok = in_cam.zc > depth_lim;
        prj_next.w_nz     = img_w != '0;
        prj_next.h_nz     = img_h != '0;
    end

    // Stage four: with positive depth, the truncated pixel lies inside the image
    // exactly when f*x + (c+1)*z > 0 and f*x < (size-c)*z.
    assign sum_u = prj_reg.fx + prj_reg.cu1z;
    assign sum_v = prj_reg.fy + prj_reg.cv1z;

    assign inside_next = prj_reg.depth_ok && prj_reg.w_nz && prj_reg.h_nz
                      && (sum_u > 0) && (prj_reg.fx < prj_reg.wz)
                      && (sum_v > 0) && (prj_reg.fy < prj_reg.hz);

    always_ff @(posedge clk)
    begin
        if (en3)
            prj_reg <= prj_next;
        if (en4)
        begin
            pt4_reg    <= prj_reg.pt;
            inside_reg <= inside_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_pt     = pt4_reg;
    assign out_inside = inside_reg;

endmodule

/* test/tb.sv */
// Self-checking testbench of the lidar point filter against the camera field of view.
module tb;

    import lcfpf_pkg::*;

    localparam int     CLK_HALF    = 10;
    localparam int     LIMIT_TICKS = 200000;
    localparam int     SETTLE      = 8;
    localparam longint Q14_ONE     = longint'(1) << FRAC_BITS;

    // Kinds of camera setup that the run steps through.
    typedef enum int {
        SETUP_DEFAULT,
        SETUP_RANDOM,
        SETUP_EXTREME,
        SETUP_TIGHT,
        SETUP_ZERO_FOCAL,
        SETUP_EMPTY,
        SETUP_OFF_CENTRE
    } setup_t;

    // A point as sent, with the visibility that it should come back with.
    typedef struct packed {
        point_t pt;
        logic   visible;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [COORD_WIDTH-1:0] point_x = '0;
    logic signed [COORD_WIDTH-1:0] point_y = '0;
    logic signed [COORD_WIDTH-1:0] point_z = '0;
    logic                          frame_end = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [COORD_WIDTH-1:0] kept_x;
    logic signed [COORD_WIDTH-1:0] kept_y;
    logic signed [COORD_WIDTH-1:0] kept_z;
    logic                          inside_res;
    logic                          scan_end;

    // Our own copy of the camera setup, starting from the reset values.
    logic [ROT_W-1:0]         rot_row [3] = '{ROT_ROW_0_RST, ROT_ROW_1_RST, ROT_ROW_2_RST};
    logic [TRANS_W-1:0]       shift_xyz = TRANS_RST;
    logic [PIXEL_WIDTH-1:0]   focal = FOCAL_RST;
    logic [2*PIXEL_WIDTH-1:0] centre = CENTER_RST;
    logic [2*PIXEL_WIDTH-1:0] img_size = SIZE_RST;
    logic [DEPTH_W-1:0]       depth_floor = MIN_DEPTH_RST;

    point_t   points_to_send [$];
    verdict_t verdicts_due [$];
    verdict_t head;
    verdict_t arrival;
    int       sender_idle_pct = 0;
    int       stall_pct = 0;
    int       fault_count = 0;

    lidar_camera_fov_point_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kept_x     (kept_x),
        .kept_y     (kept_y),
        .kept_z     (kept_z),
        .inside_res (inside_res),
        .scan_end   (scan_end)
    );

    // Clock with a period of twenty time units.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // True when trunc(gain*num/den + origin) falls in [0, extent-1], given den > 0.
    function automatic bit fits_axis(input longint num, input longint den, input longint gain,
                                     input longint origin, input longint extent);
        if (extent <= 0)
            return 1'b0;
        return (gain * num + (origin + 1) * den > 0) && (gain * num < (extent - origin) * den);
    endfunction

    // Carries a lidar point into the camera frame and decides whether the camera sees it.
    function automatic logic camera_sees(input point_t p);
        longint lidar [3];
        longint cam [3];
        longint f;
        longint cu;
        longint cv;
        longint w;
        longint h;
        int     i;
        int     j;
        lidar[0] = $signed(p.x);
        lidar[1] = $signed(p.y);
        lidar[2] = $signed(p.z);
        // Exact transform in units of 2^-24 m.
        for (i = 0; i < 3; i++)
        begin
            cam[i] = longint'($signed(shift_xyz[COORD_WIDTH*(2-i) +: COORD_WIDTH])) * Q14_ONE;
            for (j = 0; j < 3; j++)
                cam[i] += longint'($signed(rot_row[i][COEF_BITS*(2-j) +: COEF_BITS])) * lidar[j];
        end
        f  = focal;
        cu = centre[2*PIXEL_WIDTH-1:PIXEL_WIDTH];
        cv = centre[PIXEL_WIDTH-1:0];
        w  = img_size[2*PIXEL_WIDTH-1:PIXEL_WIDTH];
        h  = img_size[PIXEL_WIDTH-1:0];
        // Camera depth is the lidar forward axis; image x and y are minus lidar y and z.
        if (cam[0] <= longint'(depth_floor) * Q14_ONE)
            return 1'b0;
        return fits_axis(-cam[1], cam[0], f, cu, w) && fits_axis(-cam[2], cam[0], f, cv, h);
    endfunction

    // Picks one of the coordinate extremes, minus one or zero.
    function automatic logic [COORD_WIDTH-1:0] extreme_coord();
        case ($urandom_range(3))
            0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            2: return '1;
            default: return '0;
        endcase
    endfunction

    // Mostly points ahead of the sensor within a cone, with some noise and extremes.
    function automatic point_t draw_point();
        point_t p;
        int     reach;
        p.frame_end = ($urandom_range(15) == 0);
        case ($urandom_range(9))
            0, 1:
            begin
                p.x = COORD_WIDTH'($urandom);
                p.y = COORD_WIDTH'($urandom);
                p.z = COORD_WIDTH'($urandom);
            end
            2:
            begin
                p.x = extreme_coord();
                p.y = extreme_coord();
                p.z = extreme_coord();
            end
            default:
            begin
                reach = $urandom_range(200000, 1);
                p.x = COORD_WIDTH'(reach);
                p.y = COORD_WIDTH'(int'($urandom_range(2 * reach)) - reach);
                p.z = COORD_WIDTH'(int'($urandom_range(2 * reach)) - reach);
            end
        endcase
        return p;
    endfunction

    function automatic void queue_point(input int x, input int y, input int z, input bit last);
        point_t p;
        p.x = COORD_WIDTH'(x);
        p.y = COORD_WIDTH'(y);
        p.z = COORD_WIDTH'(z);
        p.frame_end = last;
        points_to_send = {points_to_send, p};
    endfunction

    // One register write; our copy follows at once since the block is idle.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_ROT_ROW_0:   rot_row[0] = value[ROT_W-1:0];
            REG_ROT_ROW_1:   rot_row[1] = value[ROT_W-1:0];
            REG_ROT_ROW_2:   rot_row[2] = value[ROT_W-1:0];
            REG_TRANSLATION: shift_xyz = value[TRANS_W-1:0];
            REG_FOCAL:       focal = value[PIXEL_WIDTH-1:0];
            REG_CENTER:      centre = value[2*PIXEL_WIDTH-1:0];
            REG_SIZE:        img_size = value[2*PIXEL_WIDTH-1:0];
            REG_MIN_DEPTH:   depth_floor = value[DEPTH_W-1:0];
            default:         ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Builds a whole camera setup of the given kind and writes every register.
    task automatic program_setup(input setup_t kind);
        logic [COEF_BITS-1:0]   c [9];
        logic [COORD_WIDTH-1:0] t [3];
        logic [PIXEL_WIDTH-1:0] f;
        logic [PIXEL_WIDTH-1:0] cu;
        logic [PIXEL_WIDTH-1:0] cv;
        logic [PIXEL_WIDTH-1:0] w;
        logic [PIXEL_WIDTH-1:0] h;
        logic [DEPTH_W-1:0]     md;
        int                     k;
        for (k = 0; k < 9; k++)
            c[k] = (k % 4 == 0) ? COEF_BITS'(Q14_ONE) : '0;
        for (k = 0; k < 3; k++)
            t[k] = '0;
        f  = PIXEL_WIDTH'(320);
        w  = PIXEL_WIDTH'($urandom_range(4095, 1));
        h  = PIXEL_WIDTH'($urandom_range(4095, 1));
        cu = PIXEL_WIDTH'($urandom_range(w));
        cv = PIXEL_WIDTH'($urandom_range(h));
        md = DEPTH_W'($urandom_range(5000));
        case (kind)
            SETUP_DEFAULT:
            begin
                w  = PIXEL_WIDTH'(640);
                h  = PIXEL_WIDTH'(480);
                cu = PIXEL_WIDTH'(320);
                cv = PIXEL_WIDTH'(240);
                md = DEPTH_W'(102);
            end
            SETUP_RANDOM:
            begin
                // Near-rigid rotation with noise, now and then a wild coefficient.
                for (k = 0; k < 9; k++)
                begin
                    if ($urandom_range(3) == 0)
                        c[k] = COEF_BITS'($urandom);
                    else
                        c[k] = c[k] + COEF_BITS'(int'($urandom_range(6000)) - 3000);
                end
                for (k = 0; k < 3; k++)
                    t[k] = COORD_WIDTH'(int'($urandom_range(80000)) - 40000);
                f = PIXEL_WIDTH'($urandom_range(4095, 1));
            end
            SETUP_EXTREME:
            begin
                for (k = 0; k < 9; k++)
                begin
                    case ($urandom_range(4))
                        0: c[k] = 16'h8000;
                        1: c[k] = 16'h7fff;
                        2: c[k] = 16'hffff;
                        3: c[k] = 16'h0001;
                        default: ;
                    endcase
                end
                for (k = 0; k < 3; k++)
                    t[k] = extreme_coord();
                f  = '1;
                w  = '1;
                h  = '1;
                cu = $urandom_range(1) ? '1 : '0;
                cv = $urandom_range(1) ? '1 : '0;
                md = $urandom_range(1) ? '1 : '0;
            end
            SETUP_TIGHT:
            begin
                // A single pixel at the origin, unit focal length, no depth margin.
                f  = PIXEL_WIDTH'(1);
                w  = PIXEL_WIDTH'(1);
                h  = PIXEL_WIDTH'(1);
                cu = '0;
                cv = '0;
                md = '0;
            end
            SETUP_ZERO_FOCAL:
                f = '0;
            SETUP_EMPTY:
            begin
                if ($urandom_range(1))
                    w = '0;
                else
                    h = '0;
            end
            SETUP_OFF_CENTRE:
            begin
                // Principal point beyond the image on at least one axis.
                w  = PIXEL_WIDTH'($urandom_range(2000, 1));
                h  = PIXEL_WIDTH'($urandom_range(2000, 1));
                cu = PIXEL_WIDTH'(int'(w) + int'($urandom_range(1000)));
                cv = $urandom_range(1) ? PIXEL_WIDTH'(int'(h) + int'($urandom_range(1000))) : cv;
            end
            default: ;
        endcase
        set_register(REG_ROT_ROW_0, CFG_DATA_W'({c[0], c[1], c[2]}));
        set_register(REG_ROT_ROW_1, CFG_DATA_W'({c[3], c[4], c[5]}));
        set_register(REG_ROT_ROW_2, CFG_DATA_W'({c[6], c[7], c[8]}));
        set_register(REG_TRANSLATION, CFG_DATA_W'({t[0], t[1], t[2]}));
        set_register(REG_FOCAL, CFG_DATA_W'(f));
        set_register(REG_CENTER, CFG_DATA_W'({cu, cv}));
        set_register(REG_SIZE, CFG_DATA_W'({w, h}));
        set_register(REG_MIN_DEPTH, CFG_DATA_W'(md));
    endtask

    // Waits until every point has been sent and answered, then lets the pipeline settle.
    // The state is sampled on the falling edge, once the rising-edge updates have landed.
    task automatic drain();
        while (points_to_send.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sends a batch of random points under one idling profile and waits for all answers.
    task automatic run_batch(input int count, input int send_pct, input int hold_pct);
        int n;
        sender_idle_pct = send_pct;
        stall_pct = hold_pct;
        for (n = 0; n < count; n++)
            points_to_send = {points_to_send, draw_point()};
        drain();
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Input side: offers queued points, holding each beat steady while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                arrival.pt      = '{point_x, point_y, point_z, frame_end};
                arrival.visible = camera_sees(arrival.pt);
                verdicts_due    = {verdicts_due, arrival};
            end
            if (!in_valid || !in_stall)
            begin
                if (points_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    point_x   <= points_to_send[0].x;
                    point_y   <= points_to_send[0].y;
                    point_z   <= points_to_send[0].z;
                    frame_end <= points_to_send[0].frame_end;
                    in_valid  <= 1'b1;
                    points_to_send.delete(0);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each result beat against the oldest outstanding point.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result beat arrived with no point outstanding");
                    fault_count++;
                end
                else
                begin
                    head = verdicts_due.pop_front();
                    compare_field("kept_x", head.pt.x, kept_x);
                    compare_field("kept_y", head.pt.y, kept_y);
                    compare_field("kept_z", head.pt.z, kept_z);
                    compare_field("inside_res", {31'd0, head.visible}, {31'd0, inside_res});
                    compare_field("scan_end", {31'd0, head.pt.frame_end}, {31'd0, scan_end});
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Guard against a hung pipeline.
    initial
    begin
        #(2 * CLK_HALF * LIMIT_TICKS);
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence: reset, directed points, then random batches over several setups.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup: centre, depth threshold, behind, image edges and truncation, extremes.
        queue_point(1024, 0, 0, 0);
        queue_point(102, 0, 0, 0);
        queue_point(103, 0, 0, 0);
        queue_point(-1024, 0, 0, 0);
        queue_point(0, 0, 0, 1);
        queue_point(1024, -1023, 0, 0);
        queue_point(1024, -1024, 0, 0);
        queue_point(1024, 1027, 0, 0);
        queue_point(1024, 1028, 0, 0);
        queue_point(1024, 0, -767, 0);
        queue_point(1024, 0, -768, 0);
        queue_point(1024, 0, 771, 0);
        queue_point(1024, 0, 772, 1);
        queue_point(524287, 524287, 524287, 0);
        queue_point(-524288, -524288, -524288, 1);
        queue_point(524287, -524288, 0, 0);
        queue_point(524287, 0, -524288, 0);
        queue_point(-1, -1, -1, 1);
        queue_point(524287, 1, -1, 0);
        drain();

        run_batch(60, 0, 0);
        program_setup(SETUP_RANDOM);
        run_batch(40, 81, 0);
        run_batch(40, 81, 0);
        program_setup(SETUP_EXTREME);
        run_batch(60, 0, 81);
        program_setup(SETUP_TIGHT);
        run_batch(60, 9, 9);
        program_setup(SETUP_ZERO_FOCAL);
        run_batch(50, 0, 0);
        program_setup(SETUP_EMPTY);
        run_batch(40, 81, 0);
        program_setup(SETUP_OFF_CENTRE);
        run_batch(50, 0, 81);
        program_setup(SETUP_EXTREME);
        run_batch(50, 9, 9);
        program_setup(SETUP_RANDOM);
        run_batch(50, 0, 0);
        program_setup(SETUP_DEFAULT);
        run_batch(20, 9, 9);

        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
